>>> rtl/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg: shared types for the longest dominance chain block
// Request payload structs and result kind constants.
// ----------------------------------------------------------------------------
package ldc_pkg;

	typedef struct packed {
		logic [15:0] weight;
		logic [15:0] score;
		logic        last_item;
	} in_req_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] value;
		logic       overflow;
		logic       end_of_run;
	} out_req_t;

	localparam logic KIND_LENGTH = 1'b0;
	localparam logic KIND_MEMBER = 1'b1;

endpackage

>>> rtl/ldc_cmp.sv
// ----------------------------------------------------------------------------
// ldc_cmp: shared compare unit
// Orders two entries and tests the chain relation between them.
// ----------------------------------------------------------------------------
module ldc_cmp import ldc_pkg::*; #(
	parameter int KB = 16
) (
	input  logic [KB-1:0] wa,
	input  logic [KB-1:0] sa,
	input  logic [5:0]    na,
	input  logic [KB-1:0] wb,
	input  logic [KB-1:0] sb,
	input  logic [5:0]    nb,
	output logic          a_before_b,
	output logic          a_feeds_b
);
	always_comb begin
		if (wa != wb)
			a_before_b = wa < wb;
		else if (sa != sb)
			a_before_b = sa > sb;
		else
			a_before_b = na < nb;
		a_feeds_b = (wa < wb) && (sa > sb);
	end
endmodule

>>> rtl/longest_dominance_chain.sv
// ----------------------------------------------------------------------------
// longest_dominance_chain: longest chain of rising weight and falling score
// Loads pairs, sorts them, runs a quadratic chain search, emits the chain.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// in      | in  | in_valid/in_stall | in_req_t (weight, score, last_item)
// out     | out | out_valid/out_stall | out_req_t (kind, value, overflow, end_of_run)
//
// Loading takes one pair per cycle. After the last pair come an insertion sort,
// a quadratic chain search, an end search, a walk back along the chain members
// and the emission of each result; the sort and the chain search share one
// comparator.
// arst_n clears the sequencer, the count and the overflow flag.
// Input stall is high from the last pair until the final result is taken.
module longest_dominance_chain import ldc_pkg::*; #(
	parameter int MAX_ITEMS = 32,
	parameter int KEY_BITS  = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output out_req_t out_data
);
	localparam int AW = $clog2(MAX_ITEMS);

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_SORT  = 7'b0000010,
		ST_DPI   = 7'b0000100,
		ST_DPJ   = 7'b0001000,
		ST_BEST  = 7'b0010000,
		ST_WALK  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [KEY_BITS-1:0] w_q [MAX_ITEMS];
	logic [KEY_BITS-1:0] s_q [MAX_ITEMS];
	logic [5:0] n_q [MAX_ITEMS];
	logic [5:0] len_q [MAX_ITEMS];
	logic [AW-1:0] pred_q [MAX_ITEMS];
	logic pv_q [MAX_ITEMS];
	logic [AW-1:0] chain_q [MAX_ITEMS];
	logic [6:0] cnt_q;
	logic ovf_q;
	logic [6:0] i_q, j_q, k_q;
	logic [5:0] pmax_q;
	logic found_q;
	logic [AW-1:0] pidx_q, best_q, pos_q;
	logic out_v_q;
	out_req_t out_q;

	// Sort compares entry j against j-1; the chain search compares the
	// candidate at j-1 against entry i.
	logic [AW-1:0] jm, ja, jb;
	logic a_first, feeds;
	assign jm = AW'(j_q - 7'd1);
	assign ja = (state_q == ST_SORT) ? j_q[AW-1:0] : jm;
	assign jb = (state_q == ST_SORT) ? jm : i_q[AW-1:0];

	ldc_cmp #(.KB(KEY_BITS)) u_cmp (
		.wa(w_q[ja]), .sa(s_q[ja]), .na(n_q[ja]),
		.wb(w_q[jb]), .sb(s_q[jb]), .nb(n_q[jb]),
		.a_before_b(a_first), .a_feeds_b(feeds)
	);

	logic [6:0] n_items;
	assign n_items = cnt_q;
	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = out_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && !out_stall)
				out_v_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q < 7'(MAX_ITEMS)) begin
							w_q[cnt_q[AW-1:0]] <= in_data.weight[KEY_BITS-1:0];
							s_q[cnt_q[AW-1:0]] <= in_data.score[KEY_BITS-1:0];
							n_q[cnt_q[AW-1:0]] <= 6'(cnt_q + 7'd1);
							cnt_q <= cnt_q + 7'd1;
						end else
							ovf_q <= 1'b1;
						if (in_data.last_item) begin
							state_q <= ST_SORT;
							i_q <= 7'd1;
							j_q <= 7'd1;
						end
					end
				end
				ST_SORT: begin
					if (i_q >= n_items) begin
						state_q <= ST_DPI;
						i_q <= '0;
					end else if (j_q != 7'd0 && a_first) begin
						w_q[ja] <= w_q[jb]; w_q[jb] <= w_q[ja];
						s_q[ja] <= s_q[jb]; s_q[jb] <= s_q[ja];
						n_q[ja] <= n_q[jb]; n_q[jb] <= n_q[ja];
						j_q <= j_q - 7'd1;
					end else begin
						i_q <= i_q + 7'd1;
						j_q <= i_q + 7'd1;
					end
				end
				ST_DPI: begin
					if (i_q >= n_items) begin
						state_q <= ST_BEST;
						best_q <= '0;
						k_q <= 7'd1;
					end else begin
						found_q <= 1'b0;
						pmax_q <= '0;
						pidx_q <= '0;
						j_q <= i_q;
						state_q <= ST_DPJ;
					end
				end
				ST_DPJ: begin
					if (j_q == 7'd0) begin
						pv_q[i_q[AW-1:0]] <= found_q;
						pred_q[i_q[AW-1:0]] <= pidx_q;
						len_q[i_q[AW-1:0]] <= found_q ? pmax_q + 6'd1 : 6'd1;
						i_q <= i_q + 7'd1;
						state_q <= ST_DPI;
					end else begin
						j_q <= j_q - 7'd1;
						if (feeds && (!found_q || len_q[jm] > pmax_q)) begin
							found_q <= 1'b1;
							pmax_q <= len_q[jm];
							pidx_q <= jm;
						end
					end
				end
				ST_BEST: begin
					if (k_q >= n_items) begin
						state_q <= ST_WALK;
						pos_q <= best_q;
						k_q <= '0;
					end else begin
						if (len_q[k_q[AW-1:0]] > len_q[best_q])
							best_q <= k_q[AW-1:0];
						k_q <= k_q + 7'd1;
					end
				end
				ST_WALK: begin
					chain_q[k_q[AW-1:0]] <= pos_q;
					if (!pv_q[pos_q] || k_q + 7'd1 >= n_items) begin
						state_q <= ST_EMIT;
						i_q <= k_q + 7'd1;
						j_q <= k_q + 7'd2;
					end else begin
						pos_q <= pred_q[pos_q];
						k_q <= k_q + 7'd1;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || !out_stall) begin
						if (j_q == 7'd0) begin
							state_q <= ST_LOAD;
							cnt_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							out_v_q <= 1'b1;
							out_q.overflow <= ovf_q;
							if (j_q == i_q + 7'd1) begin
								out_q.kind <= KIND_LENGTH;
								out_q.value <= len_q[best_q];
								out_q.end_of_run <= 1'b0;
							end else begin
								out_q.kind <= KIND_MEMBER;
								out_q.value <= n_q[chain_q[AW'(j_q - 7'd1)]];
								out_q.end_of_run <= (j_q == 7'd1);
							end
							j_q <= j_q - 7'd1;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> in_stall) else $error("result pending while loading");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 7'(MAX_ITEMS)) else $error("item count beyond capacity");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_stall |=> out_v_q && $stable(out_q)) else $error("result lost");
endmodule
